@@ rtl/waveform_minmax_column_decimator_unit_defines.svh @@
// assertion macros for the column decimator
`ifndef WAVEFORM_MINMAX_COLUMN_DECIMATOR_UNIT_DEFINES_SVH
`define WAVEFORM_MINMAX_COLUMN_DECIMATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked on every clock outside reset
`define WMCD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wmcd check failed");

// next-cycle implication
`define WMCD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wmcd check failed");

`endif

@@ rtl/wmcd_pkg.sv @@
package wmcd_pkg;

    localparam int SAMPLE_MIN  = 28;
    localparam int SAMPLE_MAX  = 228;
    localparam int NONE_CODE   = 0;
    localparam int MAX_COLUMNS = 1024;
    localparam int CLAMP_TOP   = 200;

    localparam int SAMPLE_W = 8;
    localparam int ROW_W    = 8;
    localparam int IDX_W    = 16;
    localparam int COL_W    = $clog2(MAX_COLUMNS);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // row mapping divisor and its reciprocal for multiply-and-shift division
    localparam int ROW_DIV     = (SAMPLE_MAX > SAMPLE_MIN) ? (SAMPLE_MAX - SAMPLE_MIN) : 1;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam longint RECIP   = ((64'd1 << RECIP_SHIFT) + ROW_DIV - 1) / ROW_DIV;
    localparam int PROD_W      = 2 * SAMPLE_W;

    // reset values of the configuration registers
    localparam int RST_NUM_SAMPLES = 281;
    localparam int RST_NUM_COLUMNS = 272;
    localparam int RST_BASE_ROW    = 16;
    localparam int RST_ROW_SPAN    = 14;
    localparam int RST_N_EFF = (RST_NUM_SAMPLES == 0) ? 1 : RST_NUM_SAMPLES;
    localparam int RST_W_RAW = (RST_NUM_COLUMNS == 0) ? 1 : RST_NUM_COLUMNS;
    localparam int RST_W_EFF = (RST_W_RAW > RST_N_EFF) ? RST_N_EFF : RST_W_RAW;
    localparam int RST_Q     = RST_N_EFF / RST_W_EFF;
    localparam int RST_R     = RST_N_EFF % RST_W_EFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_SAMPLES = 2'd0,
        CFG_NUM_COLUMNS = 2'd1,
        CFG_BASE_ROW    = 2'd2,
        CFG_ROW_SPAN    = 2'd3
    } t_cfg_idx;

    // samples per column and leftover for the boundary accumulator
    typedef struct packed {
        logic [IDX_W-1:0] quo;
        logic [COL_W-1:0] rem;
    } t_ratio;

    // one closed column, bridged raw extremes
    typedef struct packed {
        logic [COL_W-1:0]    column;
        logic [SAMPLE_W-1:0] top;
        logic [SAMPLE_W-1:0] bot;
        logic                fin;
        logic [COL_W-1:0]    extent;
    } t_col_event;

endpackage

@@ rtl/wmcd_divider.sv @@
module wmcd_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [wmcd_pkg::IDX_W-1:0]  i_numer,
    input  logic [wmcd_pkg::COL_W-1:0]  i_denom,
    output logic                        o_busy,
    output wmcd_pkg::t_ratio            o_ratio
);
    import wmcd_pkg::*;

    localparam int CNT_W = $clog2(IDX_W + 1);

    logic [IDX_W-1:0] r_quo;
    logic [COL_W-1:0] r_rem;
    logic [COL_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic [COL_W:0]   trial;
    logic             fits;

    // restoring division, one quotient bit per cycle
    assign trial = {r_rem, r_quo[IDX_W-1]};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quo <= IDX_W'(RST_Q);
            r_rem <= COL_W'(RST_R);
            r_den <= COL_W'(RST_W_EFF);
            r_cnt <= '0;
        end else if (i_start) begin
            r_quo <= i_numer;
            r_rem <= '0;
            r_den <= i_denom;
            r_cnt <= CNT_W'(IDX_W);
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[IDX_W-2:0], fits};
            r_rem <= fits ? COL_W'(trial - {1'b0, r_den}) : trial[COL_W-1:0];
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_busy      = (r_cnt != '0);
    assign o_ratio.quo = r_quo;
    assign o_ratio.rem = r_rem;

endmodule

@@ rtl/wmcd_tracker.sv @@
module wmcd_tracker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [wmcd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_start,
    input  wmcd_pkg::t_ratio              i_ratio,
    input  logic [wmcd_pkg::COL_W-1:0]    i_width,
    input  logic                          i_adv,
    output logic                          o_valid,
    output wmcd_pkg::t_col_event          o_event
);
    import wmcd_pkg::*;

    logic [IDX_W-1:0]    r_s, r_first, r_rem;
    logic [COL_W-1:0]    r_col, r_ext;
    logic [SAMPLE_W-1:0] r_min, r_max, r_pmin, r_pmax;
    logic                r_ev_valid;
    t_col_event          r_ev;

    logic [IDX_W-1:0]    e_s, e_first, e_rem, n_s, n_first, n_rem;
    logic [COL_W-1:0]    e_col, e_ext, n_col, n_ext;
    logic [SAMPLE_W-1:0] e_min, e_max, e_pmin, e_pmax;
    logic [SAMPLE_W-1:0] n_min, n_max, n_pmin, n_pmax;
    logic [IDX_W:0]      last, sum, nf;
    logic                active, close;
    t_col_event          ev;

    always_comb begin
        // record start acts on the state before this sample is taken
        e_s = r_s; e_first = r_first; e_rem = r_rem; e_col = r_col; e_ext = r_ext;
        e_min = r_min; e_max = r_max; e_pmin = r_pmin; e_pmax = r_pmax;
        if (i_start) begin
            e_s = '0; e_first = '0; e_rem = '0; e_col = '0; e_ext = '0;
            e_min = '1; e_max = '0; e_pmin = '1; e_pmax = '0;
        end
        n_s = e_s; n_first = e_first; n_rem = e_rem; n_col = e_col; n_ext = e_ext;
        n_min = e_min; n_max = e_max; n_pmin = e_pmin; n_pmax = e_pmax;

        active = (e_col < i_width) && (e_s >= e_first);
        last   = {1'b0, e_first} + {1'b0, i_ratio.quo} - (IDX_W+1)'(1);
        close  = active && ({1'b0, e_s} >= last);

        if (active) begin
            if (e_s == e_first && i_sample != SAMPLE_W'(NONE_CODE)) n_ext = e_col;
            if (i_sample < e_min) n_min = i_sample;
            if (i_sample > e_max) n_max = i_sample;
        end

        ev.column = e_col;
        ev.top    = n_max;
        ev.bot    = n_min;
        if (e_col != '0) begin
            // bridge against the previous column
            if (n_max < e_pmin) ev.top = e_pmin;
            if (n_min > e_pmax) ev.bot = e_pmax;
        end
        ev.fin    = (e_col == i_width - COL_W'(1));
        ev.extent = ev.fin ? n_ext : '0;

        sum = {1'b0, e_rem} + (IDX_W+1)'(i_ratio.rem);
        nf  = {1'b0, e_first} + {1'b0, i_ratio.quo};
        if (sum >= (IDX_W+1)'(i_width)) begin
            sum = sum - (IDX_W+1)'(i_width);
            nf  = nf + (IDX_W+1)'(1);
        end
        if (close) begin
            n_pmin  = n_min;
            n_pmax  = n_max;
            n_min   = '1;
            n_max   = '0;
            n_col   = e_col + COL_W'(1);
            n_rem   = sum[IDX_W-1:0];
            n_first = nf[IDX_W-1:0];
        end

        if (e_s != '1) n_s = e_s + IDX_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0; r_first <= '0; r_rem <= '0; r_col <= '0; r_ext <= '0;
            r_min <= '1; r_max <= '0; r_pmin <= '1; r_pmax <= '0;
        end else if (i_accept) begin
            r_s <= n_s; r_first <= n_first; r_rem <= n_rem; r_col <= n_col; r_ext <= n_ext;
            r_min <= n_min; r_max <= n_max; r_pmin <= n_pmin; r_pmax <= n_pmax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_valid <= 1'b0;
        end else if (!r_ev_valid || i_adv) begin
            r_ev_valid <= i_accept && close;
        end
        if (i_accept && close) r_ev <= ev;
    end

    assign o_valid = r_ev_valid;
    assign o_event = r_ev;

endmodule

@@ rtl/wmcd_row_map.sv @@
module wmcd_row_map (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  wmcd_pkg::t_col_event        i_event,
    input  logic [wmcd_pkg::ROW_W-1:0]  i_base_row,
    input  logic [wmcd_pkg::ROW_W-1:0]  i_row_span,
    input  logic                        i_ready,
    output logic                        o_adv,
    output logic                        o_valid,
    output logic [wmcd_pkg::COL_W-1:0]  o_column,
    output logic [wmcd_pkg::ROW_W-1:0]  o_top_row,
    output logic [wmcd_pkg::ROW_W-1:0]  o_bottom_row,
    output logic                        o_final,
    output logic [wmcd_pkg::COL_W-1:0]  o_extent
);
    import wmcd_pkg::*;

    localparam int NUM_W  = PROD_W + 1;
    localparam int FULL_W = NUM_W + RECIP_W;
    localparam int QUO_W  = FULL_W - RECIP_SHIFT;

    // offset above the minimum level, clamped to the signal range
    function automatic logic [SAMPLE_W-1:0] level(input logic [SAMPLE_W-1:0] x);
        logic [SAMPLE_W-1:0] d;
        d = x - SAMPLE_W'(SAMPLE_MIN);
        if (x < SAMPLE_W'(SAMPLE_MIN)) return '0;
        if (d > SAMPLE_W'(CLAMP_TOP)) return SAMPLE_W'(CLAMP_TOP);
        return d;
    endfunction

    function automatic logic [ROW_W-1:0] to_row(input logic [NUM_W-1:0] num,
                                                input logic [ROW_W-1:0] base);
        logic [FULL_W-1:0] prod;
        logic [QUO_W-1:0]  off;
        prod = FULL_W'(num) * FULL_W'(RECIP_W'(RECIP));
        off  = prod[FULL_W-1:RECIP_SHIFT];
        if (QUO_W'(base) >= off) return ROW_W'(QUO_W'(base) - off);
        return '0;
    endfunction

    logic              r_v2, r_v3;
    logic [NUM_W-1:0]  r_top_num, r_bot_num;
    logic [COL_W-1:0]  r_col2, r_ext2;
    logic              r_fin2;
    logic [COL_W-1:0]  r_col3, r_ext3;
    logic [ROW_W-1:0]  r_top3, r_bot3;
    logic              r_fin3;
    logic              adv3;
    logic [PROD_W-1:0] top_prod, bot_prod;

    assign adv3  = !r_v3 || i_ready;
    assign o_adv = !r_v2 || adv3;

    assign top_prod = PROD_W'(i_row_span) * PROD_W'(level(i_event.top));
    assign bot_prod = PROD_W'(i_row_span) * PROD_W'(level(i_event.bot));

    // stage two: span times level plus divisor minus one gives a ceiling
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (o_adv) begin
            r_v2 <= i_valid;
        end
        if (o_adv && i_valid) begin
            r_top_num <= NUM_W'(top_prod) + NUM_W'(ROW_DIV - 1);
            r_bot_num <= NUM_W'(bot_prod) + NUM_W'(ROW_DIV - 1);
            r_col2    <= i_event.column;
            r_ext2    <= i_event.extent;
            r_fin2    <= i_event.fin;
        end
    end

    // stage three: reciprocal divide and subtract from the base row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv3) begin
            r_v3 <= r_v2;
        end
        if (adv3 && r_v2) begin
            r_top3 <= to_row(r_top_num, i_base_row);
            r_bot3 <= to_row(r_bot_num, i_base_row);
            r_col3 <= r_col2;
            r_ext3 <= r_ext2;
            r_fin3 <= r_fin2;
        end
    end

    assign o_valid      = r_v3;
    assign o_column     = r_col3;
    assign o_top_row    = r_top3;
    assign o_bottom_row = r_bot3;
    assign o_final      = r_fin3;
    assign o_extent     = r_ext3;

endmodule

@@ rtl/waveform_minmax_column_decimator_unit.sv @@
// channel   | dir | tdata (low bit up)                              | tuser        | tlast
// s_axis    | in  | sample[7:0]                                     | record_start | -
// m_axis    | out | column[9:0] top_row[17:10] bottom_row[25:18]    | -            | final_column
//           |     | last_valid_column[35:26], zero pad [39:36]      |              |
// cfg       | in  | i_cfg_we, i_cfg_index, i_cfg_wdata (no read-back)|             | -
//
// one sample transaction per cycle while s_axis_tready is high; a closed column reaches
// m_axis through the tracker register, product register and output register
// a write to num_samples or num_columns reruns a bit-serial ratio divider and
// s_axis_tready stays low from the write until the divider finishes
// synchronous active-low reset restores the register defaults and starts a record
// a result held on m_axis stalls s_axis once tracker, product and output stages are full
`include "waveform_minmax_column_decimator_unit_defines.svh"

module waveform_minmax_column_decimator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // sample[7:0]
    input  logic                              s_axis_tuser,   // record_start
    // column stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [39:0]                       m_axis_tdata,   // column, top_row,
                                                              // bottom_row, last_valid_column
    output logic                              m_axis_tlast,   // final_column
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [wmcd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wmcd_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import wmcd_pkg::*;

    // configuration registers
    logic [IDX_W-1:0] r_num_samples;
    logic [COL_W-1:0] r_num_columns;
    logic [ROW_W-1:0] r_base_row;
    logic [ROW_W-1:0] r_row_span;
    logic             r_div_start;

    // effective record length and column count
    logic [IDX_W-1:0] n_eff;
    logic [COL_W-1:0] w_raw, w_eff;

    t_ratio     ratio;
    logic       div_busy;
    logic       accept;
    logic       ev_valid;
    t_col_event ev;
    logic       map_adv;

    logic [COL_W-1:0] out_column, out_extent;
    logic [ROW_W-1:0] out_top, out_bot;
    logic             out_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_samples <= IDX_W'(RST_NUM_SAMPLES);
            r_num_columns <= COL_W'(RST_NUM_COLUMNS);
            r_base_row    <= ROW_W'(RST_BASE_ROW);
            r_row_span    <= ROW_W'(RST_ROW_SPAN);
            r_div_start   <= 1'b0;
        end else begin
            r_div_start <= i_cfg_we && (t_cfg_idx'(i_cfg_index) == CFG_NUM_SAMPLES ||
                                        t_cfg_idx'(i_cfg_index) == CFG_NUM_COLUMNS);
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_NUM_SAMPLES: r_num_samples <= i_cfg_wdata[IDX_W-1:0];
                    CFG_NUM_COLUMNS: r_num_columns <= i_cfg_wdata[COL_W-1:0];
                    CFG_BASE_ROW:    r_base_row    <= i_cfg_wdata[ROW_W-1:0];
                    CFG_ROW_SPAN:    r_row_span    <= i_cfg_wdata[ROW_W-1:0];
                endcase
            end
        end
    end

    // zero counts act as one, and never more columns than samples
    assign n_eff = (r_num_samples == '0) ? IDX_W'(1) : r_num_samples;
    assign w_raw = (r_num_columns == '0) ? COL_W'(1) : r_num_columns;
    assign w_eff = (IDX_W'(w_raw) > n_eff) ? n_eff[COL_W-1:0] : w_raw;

    wmcd_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_numer (n_eff),
        .i_denom (w_eff),
        .o_busy  (div_busy),
        .o_ratio (ratio)
    );

    // hold samples off while the ratio is recomputed, a register is written or the tracker's event cannot advance
    assign s_axis_tready = !div_busy && !r_div_start && !i_cfg_we && (!ev_valid || map_adv);
    assign accept        = s_axis_tvalid && s_axis_tready;

    wmcd_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_sample (s_axis_tdata),
        .i_start  (s_axis_tuser),
        .i_ratio  (ratio),
        .i_width  (w_eff),
        .i_adv    (map_adv),
        .o_valid  (ev_valid),
        .o_event  (ev)
    );

    wmcd_row_map u_row_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (ev_valid),
        .i_event      (ev),
        .i_base_row   (r_base_row),
        .i_row_span   (r_row_span),
        .i_ready      (m_axis_tready),
        .o_adv        (map_adv),
        .o_valid      (m_axis_tvalid),
        .o_column     (out_column),
        .o_top_row    (out_top),
        .o_bottom_row (out_bot),
        .o_final      (out_final),
        .o_extent     (out_extent)
    );

    // pack the result fields, lowest field first
    assign m_axis_tdata = {4'b0, out_extent, out_bot, out_top, out_column};
    assign m_axis_tlast = out_final;

    // the last column of a record is the one just below the column count
    `WMCD_ASSERT_IMP(a_final_is_last_col, m_axis_tvalid && m_axis_tlast, out_column == w_eff - COL_W'(1))
    // the extent field is only filled on the final column
    `WMCD_ASSERT_IMP(a_extent_only_final, m_axis_tvalid && !m_axis_tlast, out_extent == '0)
    // a ratio recompute keeps the input closed on the following cycle
    `WMCD_ASSERT_NXT(a_div_runs, r_div_start, div_busy && !s_axis_tready)

endmodule

@@ tb/waveform_minmax_column_decimator_unit_tb.sv @@
`timescale 1ns / 1ps

module waveform_minmax_column_decimator_unit_tb;
    import wmcd_pkg::*;

    // one closed column as it appears on the column stream
    typedef struct packed {
        bit [9:0] column;
        bit [7:0] top_row;
        bit [7:0] bottom_row;
        bit       final_column;
        bit [9:0] last_valid;
    } t_column_result;

    // tracks the decimator state and holds the columns still owed by the block
    class t_column_scoreboard;
        bit [15:0] num_samples;
        bit [9:0]  num_columns;
        bit [7:0]  base_row;
        bit [7:0]  row_span;

        bit [15:0] sample_index;
        bit [9:0]  column_index;
        bit [15:0] boundary_rem;
        bit [15:0] column_first;
        bit [7:0]  running_min;
        bit [7:0]  running_max;
        bit [7:0]  prev_min;
        bit [7:0]  prev_max;
        bit [9:0]  valid_extent;

        t_column_result expected_columns[$];
        int error_count;

        function new();
            num_samples = RST_NUM_SAMPLES;
            num_columns = RST_NUM_COLUMNS;
            base_row    = RST_BASE_ROW;
            row_span    = RST_ROW_SPAN;
            error_count = 0;
            restart_record();
        endfunction

        function void restart_record();
            sample_index = '0;
            column_index = '0;
            boundary_rem = '0;
            column_first = '0;
            running_min  = 8'hFF;
            running_max  = 8'h00;
            prev_min     = 8'hFF;
            prev_max     = 8'h00;
            valid_extent = '0;
        endfunction

        function void write_register(t_cfg_idx idx, bit [15:0] value);
            case (idx)
                CFG_NUM_SAMPLES: num_samples = value;
                CFG_NUM_COLUMNS: num_columns = value[9:0];
                CFG_BASE_ROW:    base_row    = value[7:0];
                CFG_ROW_SPAN:    row_span    = value[7:0];
                default: ;
            endcase
        endfunction

        // clamp above SAMPLE_MIN, then base_row - ceil(span*v/d), floored at 0
        function bit [7:0] row_of(bit [7:0] level);
            int divisor;
            int offset;
            int num;
            divisor = (SAMPLE_MAX > SAMPLE_MIN) ? (SAMPLE_MAX - SAMPLE_MIN) : 1;
            offset  = int'(level) - SAMPLE_MIN;
            if (offset < 0) offset = 0;
            if (offset > CLAMP_TOP) offset = CLAMP_TOP;
            num = int'(base_row) * divisor - int'(row_span) * offset;
            if (num < 0) return 8'd0;
            return 8'(num / divisor);
        endfunction

        function void note_sample(bit [7:0] level, bit start);
            int n;
            int w;
            int quo;
            int rem;
            int s;
            int sum;
            int next_first;
            bit [7:0] top;
            bit [7:0] bot;
            t_column_result res;

            n = (num_samples == 0) ? 1 : int'(num_samples);
            w = (num_columns == 0) ? 1 : int'(num_columns);
            if (w > n) w = n;
            quo = n / w;
            rem = n % w;

            if (start) restart_record();

            s = sample_index;
            if (int'(column_index) < w && s >= int'(column_first)) begin
                if (s == int'(column_first) && level != 8'(NONE_CODE))
                    valid_extent = column_index;
                if (level < running_min) running_min = level;
                if (level > running_max) running_max = level;

                // a late boundary closes the column on the current sample
                if (s >= int'(column_first) + quo - 1) begin
                    top = running_max;
                    bot = running_min;
                    if (column_index > 0) begin
                        if (top < prev_min) top = prev_min;
                        if (bot > prev_max) bot = prev_max;
                    end
                    res.column       = column_index;
                    res.top_row      = row_of(top);
                    res.bottom_row   = row_of(bot);
                    res.final_column = (int'(column_index) == w - 1);
                    res.last_valid   = res.final_column ? valid_extent : '0;
                    expected_columns.push_back(res);

                    prev_min     = running_min;
                    prev_max     = running_max;
                    running_min  = 8'hFF;
                    running_max  = 8'h00;
                    column_index = column_index + 10'd1;

                    sum        = int'(boundary_rem) + rem;
                    next_first = int'(column_first) + quo;
                    if (sum >= w) begin
                        sum        = sum - w;
                        next_first = next_first + 1;
                    end
                    boundary_rem = 16'(sum);
                    column_first = 16'(next_first);
                end
            end

            if (sample_index != 16'hFFFF) sample_index = sample_index + 16'd1;
        endfunction

        function void check_column(bit [39:0] data, bit last);
            t_column_result want;
            int want_f[5];
            int got_f[5];
            string field_names[5];

            if (expected_columns.size() == 0) begin
                $display("%0t: column transaction with nothing expected, got column %0d",
                         $time, data[9:0]);
                error_count++;
                return;
            end
            want = expected_columns.pop_front();
            field_names = '{"column", "top_row", "bottom_row", "final_column",
                            "last_valid_column"};
            want_f = '{want.column, want.top_row, want.bottom_row, want.final_column,
                       want.last_valid};
            got_f  = '{data[9:0], data[17:10], data[25:18], last, data[35:26]};
            foreach (want_f[i]) begin
                if (want_f[i] != got_f[i]) begin
                    $display("%0t: %s mismatch on column %0d: expected %0d, actual %0d",
                             $time, field_names[i], want.column, want_f[i], got_f[i]);
                    error_count++;
                end
            end
        endfunction
    endclass

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // sample stream, driven by the sender tasks
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = '0;   // sample[7:0]
    logic       s_axis_tuser  = 1'b0; // record_start

    // column stream, ready driven by its own stall process
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;  // column, top_row, bottom_row, last_valid_column, pad
    logic        m_axis_tlast;  // final_column

    // register writes
    logic             i_cfg_we    = 1'b0;
    t_cfg_idx         i_cfg_index = CFG_NUM_SAMPLES;
    logic [15:0]      i_cfg_wdata = '0;

    t_column_scoreboard sb;

    // sender burst state
    int burst_left = 0;

    // handshakes between the main sequence and the receiver
    bit hold_req = 1'b0;
    bit flush    = 1'b0;

    waveform_minmax_column_decimator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // sample transactions feed the tracker, column transactions are checked
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_sample(s_axis_tdata, s_axis_tuser);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_column(m_axis_tdata, m_axis_tlast);
    end

    // sample values: none code, the clamp corners, and anything else
    function automatic bit [7:0] pick_level();
        bit [7:0] corners[6];
        corners = '{8'h00, 8'hFF, 8'(SAMPLE_MIN - 1), 8'(SAMPLE_MIN), 8'(SAMPLE_MAX),
                    8'(SAMPLE_MAX + 1)};
        case ($urandom_range(0, 11))
            0:       return 8'(NONE_CODE);
            1, 2:    return corners[$urandom_range(0, 5)];
            3, 4:    return 8'($urandom_range(SAMPLE_MIN, SAMPLE_MAX));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // offer one sample; bursts of random length with random gaps between them
    task automatic send_sample(input bit [7:0] level, input bit start);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= level;
        s_axis_tuser  <= start;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
    endtask

    // mostly whole records, plus truncated ones, overlong ones and stray starts;
    // with open_start the first record carries on the record already in flight
    task automatic send_records(input int target, input bit open_start);
        int sent;
        int len;
        int kind;
        int n_eff;
        bit start;
        sent = 0;
        while (sent < target) begin
            n_eff = (sb.num_samples == 0) ? 1 : int'(sb.num_samples);
            kind  = $urandom_range(0, 9);
            len   = n_eff;
            if (kind == 7) len = $urandom_range(1, n_eff);
            if (kind == 8) len = n_eff + $urandom_range(1, 6);
            if (len > target - sent) len = target - sent;
            for (int i = 0; i < len; i++) begin
                start = (i == 0 && !(open_start && sent == 0))
                     || (kind == 9 && $urandom_range(0, 31) == 0);
                send_sample(pick_level(), start);
            end
            sent += len;
        end
    endtask

    // stop offering and let every owed column come out, plus pipeline slack
    task automatic wait_columns_out();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_columns.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input bit [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        sb.write_register(idx, value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // unused upper bits of the narrow registers get random values
    task automatic set_config(input int n, input int w, input int base, input int span);
        write_reg(CFG_NUM_SAMPLES, 16'(n));
        write_reg(CFG_NUM_COLUMNS, (16'($urandom) & 16'hFC00) | 16'(w));
        write_reg(CFG_BASE_ROW,    (16'($urandom) & 16'hFF00) | 16'(base));
        write_reg(CFG_ROW_SPAN,    (16'($urandom) & 16'hFF00) | 16'(span));
    endtask

    // receiver: segments of free flow, random stalls and heavy stalls, a long
    // hold-off on request, and always ready while the run drains
    initial begin
        int seg;
        int mode;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else if (flush) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                seg  = $urandom_range(1, 60);
                mode = $urandom_range(0, 3);
                repeat (seg) begin
                    case (mode)
                        0, 1:    m_axis_tready <= 1'b1;
                        2:       m_axis_tready <= 1'($urandom_range(0, 1));
                        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // main sequence
    initial begin
        bit [7:0] directed_levels[22];
        directed_levels = '{8'd0, 8'd255, 8'd0, 8'd28, 8'd228, 8'd27, 8'd229, 8'd1,
                            8'd254, 8'd128, 8'd0, 8'd100, 8'd200, 8'd0, 8'd255, 8'd29,
                            8'd227, 8'd128, 8'd0, 8'd64, 8'd192, 8'd255};
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: one or two samples per column, so nearly every extreme closes a column;
        // the record opens on the none code and restarts midway
        for (int i = 0; i < 22; i++)
            send_sample(directed_levels[i], i == 0 || i == 12);
        send_records(150, 1'b1);
        wait_columns_out();

        // smallest record and column count, rows at the top of the range
        set_config(1, 1, 255, 255);
        send_records(80, 1'b0);
        wait_columns_out();

        // zero registers act as one
        set_config(0, 0, 0, 0);
        send_records(60, 1'b0);
        wait_columns_out();

        // wide columns with skipped samples between them
        set_config(100, 7, 200, 100);
        send_records(150, 1'b0);
        wait_columns_out();

        // more columns than samples, plus samples past the final column
        set_config(10, 50, 128, 255);
        send_records(100, 1'b0);
        wait_columns_out();

        // shrink the record mid-column so the open column closes late
        set_config(100, 7, 40, 60);
        for (int i = 0; i < 50; i++)
            send_sample(pick_level(), i == 0);
        wait_columns_out();
        write_reg(CFG_NUM_SAMPLES, 16'd20);
        send_records(80, 1'b1);
        wait_columns_out();

        // a column per sample or two while the receiver holds off, so the block
        // backs up into its input; rows fall below zero here
        hold_req = 1'b1;
        set_config(1500, 1023, 90, 200);
        send_records(250, 1'b0);
        wait_columns_out();

        // largest register values, only the first few columns of a record
        set_config(65535, 1023, 255, 0);
        send_records(200, 1'b0);
        wait_columns_out();

        // back to the reset settings
        set_config(RST_NUM_SAMPLES, RST_NUM_COLUMNS, RST_BASE_ROW, RST_ROW_SPAN);
        send_records(200, 1'b0);

        flush = 1'b1;
        wait_columns_out();
        repeat (10) @(posedge i_clk);
        if (sb.error_count == 0) begin
            $display("waveform_minmax_column_decimator_unit_tb: done, clean");
        end else begin
            $display("waveform_minmax_column_decimator_unit_tb: done, errors");
        end
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #50_000_000;
        $display("waveform_minmax_column_decimator_unit_tb: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/wmcd_pkg.sv
rtl/wmcd_divider.sv
rtl/wmcd_tracker.sv
rtl/wmcd_row_map.sv
rtl/waveform_minmax_column_decimator_unit.sv
tb/waveform_minmax_column_decimator_unit_tb.sv
